@@ rtl/spvm_pkg.sv @@
// ----------------------------------------------------------------------------
// spvm_pkg
// Shared types and constants for the sample playback voice mixer.
// ----------------------------------------------------------------------------
package spvm_pkg;

  localparam int VOICE_COUNT        = 8;
  localparam int VOICE_W            = 3;
  localparam int SAMPLE_WORDS       = 65536;
  localparam int ADDR_W             = 16;
  localparam int GAIN_FRACTION_BITS = 14;
  localparam int ACC_W              = 40;

  typedef enum logic [1:0] {
    OP_WRITE_SAMPLE = 2'd0,
    OP_SET_VOICE    = 2'd1,
    OP_TICK         = 2'd2,
    OP_NONE         = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_READ_L,
    ST_MAC_L,
    ST_MAC_R,
    ST_NEXT,
    ST_DONE
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic acc_l;
    logic acc_r;
  } mac_ctrl_t;

endpackage

@@ rtl/spvm_mac.sv @@
// ----------------------------------------------------------------------------
// spvm_mac
// Shared 16x16 multiplier with left and right accumulators, final shift and
// saturation.
// ----------------------------------------------------------------------------
module spvm_mac (
  input  logic                       clk,
  input  spvm_pkg::mac_ctrl_t        ctrl,
  input  logic signed [15:0]         sample,
  input  logic [15:0]                gain,
  output logic signed [15:0]         left_sat,
  output logic signed [15:0]         right_sat,
  output logic                       clip
);

  logic signed [spvm_pkg::ACC_W-1:0] acc_l_r, acc_l_nxt;
  logic signed [spvm_pkg::ACC_W-1:0] acc_r_r, acc_r_nxt;
  logic signed [32:0]                prod;
  logic signed [spvm_pkg::ACC_W-1:0] sh_l, sh_r;
  logic                              cl_l, cl_r;

  assign prod = 33'(sample) * $signed({1'b0, gain});

  always_comb begin
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    if (ctrl.clear) begin
      acc_l_nxt = '0;
      acc_r_nxt = '0;
    end else if (ctrl.acc_l) begin
      acc_l_nxt = acc_l_r + spvm_pkg::ACC_W'(prod);
    end else if (ctrl.acc_r) begin
      acc_r_nxt = acc_r_r + spvm_pkg::ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
  end

  // arithmetic shift rounds toward minus infinity
  assign sh_l = acc_l_r >>> spvm_pkg::GAIN_FRACTION_BITS;
  assign sh_r = acc_r_r >>> spvm_pkg::GAIN_FRACTION_BITS;

  always_comb begin
    cl_l = 1'b0;
    cl_r = 1'b0;
    left_sat  = sh_l[15:0];
    right_sat = sh_r[15:0];
    if (sh_l > 40'sd32767) begin
      left_sat = 16'sh7fff; cl_l = 1'b1;
    end else if (sh_l < -40'sd32768) begin
      left_sat = 16'sh8000; cl_l = 1'b1;
    end
    if (sh_r > 40'sd32767) begin
      right_sat = 16'sh7fff; cl_r = 1'b1;
    end else if (sh_r < -40'sd32768) begin
      right_sat = 16'sh8000; cl_r = 1'b1;
    end
    clip = cl_l | cl_r;
  end

endmodule

@@ rtl/sample_playback_voice_mixer.sv @@
// ----------------------------------------------------------------------------
// sample_playback_voice_mixer
// Eight-voice sample player: sample store, per-voice settings, tick mixer.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports
// in       in   in_valid, in_stall, in_operation .. in_restart
// out      out  out_valid, out_stall, out_left_out .. out_clipped
//
// A tick walks the voices one at a time through the sample memory read port
// and the shared multiplier: a voice that plays passes STEP, READ_L, MAC_L,
// MAC_R and NEXT, one that is off or ends only STEP and NEXT; DONE then loads
// the result register. Reset clears all voice state but sets frame counts to 1;
// sample memory is undefined until written. A finished frame waits while the
// previous result is still stalled; the block takes a new request in the
// cycle after the frame is loaded.
module sample_playback_voice_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_address,
  input  logic signed [15:0] in_sample_value,
  input  logic [2:0]         in_voice,
  input  logic [15:0]        in_frame_count,
  input  logic               in_stereo_source,
  input  logic               in_loop,
  input  logic [23:0]        in_speed,
  input  logic [15:0]        in_left_gain,
  input  logic [15:0]        in_right_gain,
  input  logic               in_enable,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  output logic [3:0]         out_active_voices,
  output logic [7:0]         out_finished_mask,
  output logic               out_clipped
);

  localparam int VC = spvm_pkg::VOICE_COUNT;
  localparam int VW = spvm_pkg::VOICE_W;

  logic [15:0] mem [spvm_pkg::SAMPLE_WORDS];
  logic [15:0] rd_r;
  logic [spvm_pkg::ADDR_W-1:0] rd_addr;
  logic        rd_en;

  logic [15:0] idx_r   [VC];
  logic [15:0] ph_r    [VC];
  logic [VC-1:0] en_r;
  logic [15:0] start_r [VC];
  logic [15:0] len_r   [VC];
  logic [VC-1:0] st_r;
  logic [VC-1:0] lp_r;
  logic [23:0] spd_r   [VC];
  logic [15:0] lg_r    [VC];
  logic [15:0] rg_r    [VC];

  spvm_pkg::state_t state_r, state_nxt;
  logic [VW-1:0] v_r;
  logic [3:0]    act_r;
  logic [7:0]    fin_r;
  logic [15:0]   base_r;

  logic accept;
  logic out_load;
  spvm_pkg::mac_ctrl_t mc;
  logic signed [15:0] lsat, rsat;
  logic clip;

  logic [24:0] sum;
  logic [24:0] nxt;
  logic        wrap;
  logic [15:0] new_idx;
  logic [15:0] base_c;

  assign in_stall = (state_r != spvm_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // frame moves to the result register once the previous one is gone
  assign out_load = (state_r == spvm_pkg::ST_DONE) && (!out_valid || !out_stall);

  assign sum     = 25'(ph_r[v_r]) + 25'(spd_r[v_r]);
  assign nxt     = 25'(idx_r[v_r]) + 25'(sum[24:16]);
  assign wrap    = nxt >= 25'(len_r[v_r]);
  assign new_idx = wrap ? 16'd0 : nxt[15:0];
  assign base_c  = start_r[v_r] + (st_r[v_r] ? {new_idx[14:0], 1'b0} : new_idx);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spvm_pkg::ST_IDLE:
        if (accept && in_operation == spvm_pkg::OP_TICK) state_nxt = spvm_pkg::ST_STEP;
      spvm_pkg::ST_STEP:
        state_nxt = (en_r[v_r] && !(wrap && !lp_r[v_r])) ? spvm_pkg::ST_READ_L
                                                        : spvm_pkg::ST_NEXT;
      spvm_pkg::ST_READ_L: state_nxt = spvm_pkg::ST_MAC_L;
      spvm_pkg::ST_MAC_L:  state_nxt = spvm_pkg::ST_MAC_R;
      spvm_pkg::ST_MAC_R:  state_nxt = spvm_pkg::ST_NEXT;
      spvm_pkg::ST_NEXT:
        state_nxt = (v_r == VW'(VC - 1)) ? spvm_pkg::ST_DONE : spvm_pkg::ST_STEP;
      spvm_pkg::ST_DONE:
        state_nxt = out_load ? spvm_pkg::ST_IDLE : spvm_pkg::ST_DONE;
      default:             state_nxt = spvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mc = '0;
    rd_en = 1'b0;
    rd_addr = base_r;
    case (state_r)
      spvm_pkg::ST_IDLE:   mc.clear = 1'b1;
      spvm_pkg::ST_READ_L: rd_en = 1'b1;
      spvm_pkg::ST_MAC_L: begin
        mc.acc_l = 1'b1;
        rd_en = 1'b1;
        rd_addr = base_r + {15'd0, st_r[v_r]};
      end
      spvm_pkg::ST_MAC_R:  mc.acc_r = 1'b1;
      default: ;
    endcase
  end

  // MAC_L uses left word, MAC_R right word; gain picked by state
  spvm_mac u_mac (
    .clk       (clk),
    .ctrl      (mc),
    .sample    (rd_r),
    .gain      (state_r == spvm_pkg::ST_MAC_R ? rg_r[v_r] : lg_r[v_r]),
    .left_sat  (lsat),
    .right_sat (rsat),
    .clip      (clip)
  );

  always_ff @(posedge clk) begin
    if (accept && in_operation == spvm_pkg::OP_WRITE_SAMPLE)
      mem[in_address] <= in_sample_value;
    if (rd_en)
      rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= spvm_pkg::ST_IDLE;
      out_valid <= 1'b0;
      en_r      <= '0;
      st_r      <= '0;
      lp_r      <= '0;
      v_r       <= '0;
      for (int i = 0; i < VC; i++) begin
        idx_r[i]   <= '0;
        ph_r[i]    <= '0;
        start_r[i] <= '0;
        len_r[i]   <= 16'd1;
        spd_r[i]   <= '0;
        lg_r[i]    <= '0;
        rg_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
      case (state_r)
        spvm_pkg::ST_IDLE: begin
          v_r   <= '0;
          act_r <= '0;
          fin_r <= '0;
          if (accept && in_operation == spvm_pkg::OP_SET_VOICE) begin
            start_r[in_voice] <= in_address;
            len_r[in_voice]   <= in_frame_count;
            st_r[in_voice]    <= in_stereo_source;
            lp_r[in_voice]    <= in_loop;
            spd_r[in_voice]   <= in_speed;
            lg_r[in_voice]    <= in_left_gain;
            rg_r[in_voice]    <= in_right_gain;
            en_r[in_voice]    <= in_enable;
            if (in_restart) begin
              idx_r[in_voice] <= '0;
              ph_r[in_voice]  <= '0;
            end
          end
        end
        spvm_pkg::ST_STEP: begin
          base_r <= base_c;
          if (en_r[v_r]) begin
            idx_r[v_r] <= new_idx;
            ph_r[v_r]  <= wrap ? 16'd0 : sum[15:0];
            if (wrap && !lp_r[v_r]) begin
              en_r[v_r]  <= 1'b0;
              fin_r[v_r] <= 1'b1;
            end else begin
              act_r <= act_r + 4'd1;
            end
          end
        end
        spvm_pkg::ST_NEXT: v_r <= v_r + VW'(1);
        spvm_pkg::ST_DONE: begin
          if (out_load) begin
            out_valid         <= 1'b1;
            out_left_out      <= lsat;
            out_right_out     <= rsat;
            out_active_voices <= act_r;
            out_finished_mask <= fin_r;
            out_clipped       <= clip;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
